// ===== rtl/ffha_pkg.sv =====
// Shared types and codes for the first-fit heap allocator.
// No dependencies; imported by the controller, the datapath and the top level.

package ffha_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned BYTES_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned NEED_W   = 13;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM  = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_g;
        logic rd_n;
        logic step_g;
        logic split_wr;
        logic hit_wr;
        logic top_wr;
        logic free_init;
        logic merge_add;
        logic free_wr;
        logic res_zero;
        logic res_oom;
        logic res_none;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic zero_req;
        logic bad_addr;
        logic g_lt_top;
        logic g_lt_h;
        logic hdr_fit;
        logic hdr_split;
        logic free_hit;
        logic oom;
        logic n_lt_top;
        logic n_alloc;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over an implicit chunk list: input and result
// channels around the controller and datapath. Depends on ffha_pkg,
// ffha_ctrl, ffha_dp and ffha_ram.
//
// Items are taken one at a time. Each chunk header visited takes a read state
// and then a test or step state, because the headers sit in a single-port-read
// memory with a registered read. An allocate that reuses a free chunk passes
// over the chunks before the fit, with one state more when the chunk is split;
// an allocate that grows the heap or runs out of memory passes every chunk in
// the heap. A free walks the chunks up to and including the one freed, then
// merges the free chunks behind it, with one test more when the merge stops
// at an allocated chunk rather than at the heap top. A zero-size allocate, or
// a free whose address is misaligned or lies below the first payload, goes
// from decode straight to the result. The emit state also waits while the
// previous result still waits unaccepted. The header memory needs no clearing
// after reset, so the block takes items from the first cycle. The next item is
// accepted while a result still waits in the output register.

module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int unsigned HEAP_GRANULES = 4096,
    parameter int unsigned HEADER_BYTES  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [BYTES_W-1:0]  s_request_bytes,
    input  logic [ADDR_W-1:0]   s_payload_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_address,
    output logic [STATUS_W-1:0] m_status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ffha_dp #(
        .HEAP_GRANULES (HEAP_GRANULES),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_opcode          (s_opcode),
        .s_request_bytes   (s_request_bytes),
        .s_payload_address (s_payload_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_address         (m_address),
        .m_status          (m_status),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule

// ===== rtl/ffha_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.

module ffha_ram #(
    parameter int unsigned WIDTH = 14,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// Controller state machine of the first-fit heap allocator.
// Depends on ffha_pkg for the command and status structures.

module ffha_ctrl import ffha_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_A_WALK = 4'd2;
    localparam logic [3:0] S_A_TEST = 4'd3;
    localparam logic [3:0] S_A_HIT  = 4'd4;
    localparam logic [3:0] S_F_WALK = 4'd5;
    localparam logic [3:0] S_F_STEP = 4'd6;
    localparam logic [3:0] S_F_TEST = 4'd7;
    localparam logic [3:0] S_M_CHK  = 4'd8;
    localparam logic [3:0] S_M_TEST = 4'd9;
    localparam logic [3:0] S_F_WR   = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.is_free) begin
                    if (stat.bad_addr) begin
                        cmd.res_none = 1'b1;
                        state_next   = S_EMIT;
                    end else begin
                        state_next = S_F_WALK;
                    end
                end else if (stat.zero_req) begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    state_next = S_A_WALK;
                end
            end
            S_A_WALK: begin
                if (stat.g_lt_top) begin
                    cmd.rd_g   = 1'b1;
                    state_next = S_A_TEST;
                end else if (stat.oom) begin
                    cmd.res_oom = 1'b1;
                    state_next  = S_EMIT;
                end else begin
                    cmd.top_wr = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_A_TEST: begin
                if (stat.hdr_fit) begin
                    if (stat.hdr_split) begin
                        cmd.split_wr = 1'b1;
                        state_next   = S_A_HIT;
                    end else begin
                        cmd.hit_wr = 1'b1;
                        state_next = S_EMIT;
                    end
                end else begin
                    cmd.step_g = 1'b1;
                    state_next = S_A_WALK;
                end
            end
            S_A_HIT: begin
                cmd.hit_wr = 1'b1;
                state_next = S_EMIT;
            end
            S_F_WALK: begin
                if (stat.g_lt_top && stat.g_lt_h) begin
                    cmd.rd_g   = 1'b1;
                    state_next = S_F_STEP;
                end else if (stat.g_lt_top) begin
                    cmd.rd_g   = 1'b1;
                    state_next = S_F_TEST;
                end else begin
                    cmd.res_none = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_F_STEP: begin
                cmd.step_g = 1'b1;
                state_next = S_F_WALK;
            end
            S_F_TEST: begin
                if (stat.free_hit) begin
                    cmd.free_init = 1'b1;
                    state_next    = S_M_CHK;
                end else begin
                    cmd.res_none = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_M_CHK: begin
                if (stat.n_lt_top) begin
                    cmd.rd_n   = 1'b1;
                    state_next = S_M_TEST;
                end else begin
                    state_next = S_F_WR;
                end
            end
            S_M_TEST: begin
                if (stat.n_alloc) begin
                    state_next = S_F_WR;
                end else begin
                    cmd.merge_add = 1'b1;
                    state_next    = S_M_CHK;
                end
            end
            S_F_WR: begin
                cmd.free_wr  = 1'b1;
                cmd.res_none = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ffha_dp.sv =====
// Datapath of the first-fit heap allocator: header memory, walk registers,
// heap top and the output register. Depends on ffha_pkg and ffha_ram.

module ffha_dp import ffha_pkg::*; #(
    parameter int unsigned HEAP_GRANULES = 4096,
    parameter int unsigned HEADER_BYTES  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_opcode,
    input  logic [BYTES_W-1:0]  s_request_bytes,
    input  logic [ADDR_W-1:0]   s_payload_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_address,
    output logic [STATUS_W-1:0] m_status,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat
);

    localparam int unsigned GW    = $clog2(HEAP_GRANULES);
    localparam int unsigned SW    = $clog2(HEAP_GRANULES + 1);
    localparam int unsigned HW    = SW + 1;
    localparam int unsigned CW    = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int unsigned HGRAN = (HEADER_BYTES + 15) / 16;
    localparam int unsigned PG_W  = ADDR_W - 4;

    logic                op_reg;
    logic                zero_reg;
    logic                bad_reg;
    logic [NEED_W-1:0]   need_reg;
    logic [PG_W-1:0]     h_reg;
    logic [SW-1:0]       g_reg;
    logic [SW-1:0]       n_reg;
    logic [SW-1:0]       acc_reg;
    logic [SW-1:0]       top_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_valid_reg;
    logic [ADDR_W-1:0]   m_address_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic [NEED_W-1:0]   need_in;
    logic [PG_W-1:0]     pg_in;
    logic [HW-1:0]       rdata;
    logic [SW-1:0]       hdr_sz;
    logic                hdr_a;
    logic [CW-1:0]       need_cw;
    logic [CW-1:0]       split_addr;
    logic [CW-1:0]       split_size;
    logic [CW-1:0]       g_plus_h;
    logic [CW-1:0]       top_plus_h;
    logic                we;
    logic [GW-1:0]       waddr;
    logic [HW-1:0]       wdata;
    logic                re;
    logic [GW-1:0]       raddr;

    function automatic logic [SW-1:0] next_of(
        input logic [SW-1:0] pos,
        input logic [SW-1:0] sz,
        input logic [SW-1:0] top
    );
        logic [SW:0] sum;
        sum = {1'b0, pos} + {1'b0, sz};
        if (sz == '0 || sum > {1'b0, top}) begin
            return top;
        end
        return sum[SW-1:0];
    endfunction

    assign need_in = NEED_W'(s_request_bytes[BYTES_W-1:4])
                   + NEED_W'(|s_request_bytes[3:0]) + NEED_W'(HGRAN);
    assign pg_in   = s_payload_address[ADDR_W-1:4];

    assign hdr_sz     = rdata[HW-1:1];
    assign hdr_a      = rdata[0];
    assign need_cw    = CW'(need_reg);
    assign split_addr = CW'(g_reg) + need_cw;
    assign split_size = CW'(hdr_sz) - need_cw;
    assign g_plus_h   = CW'(g_reg) + CW'(HGRAN);
    assign top_plus_h = CW'(top_reg) + CW'(HGRAN);

    always_comb begin
        we    = 1'b0;
        waddr = g_reg[GW-1:0];
        wdata = {acc_reg, 1'b0};
        priority if (cmd.split_wr) begin
            we    = 1'b1;
            waddr = split_addr[GW-1:0];
            wdata = {split_size[SW-1:0], 1'b0};
        end else if (cmd.hit_wr) begin
            we    = 1'b1;
            wdata = {need_cw[SW-1:0], 1'b1};
        end else if (cmd.top_wr) begin
            we    = 1'b1;
            waddr = top_reg[GW-1:0];
            wdata = {need_cw[SW-1:0], 1'b1};
        end else if (cmd.free_wr) begin
            we    = 1'b1;
        end else begin
            we    = 1'b0;
        end
    end

    assign re    = cmd.rd_g | cmd.rd_n;
    assign raddr = cmd.rd_n ? n_reg[GW-1:0] : g_reg[GW-1:0];

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (HEAP_GRANULES)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_opcode;
            zero_reg <= (s_request_bytes == '0);
            bad_reg  <= (s_payload_address[3:0] != 4'd0) || (CW'(pg_in) < CW'(HGRAN));
            need_reg <= need_in;
            h_reg    <= PG_W'(CW'(pg_in) - CW'(HGRAN));
        end
        if (cmd.load) begin
            g_reg <= '0;
        end else if (cmd.step_g) begin
            g_reg <= next_of(g_reg, hdr_sz, top_reg);
        end
        if (cmd.free_init) begin
            acc_reg <= hdr_sz;
            n_reg   <= next_of(g_reg, hdr_sz, top_reg);
        end else if (cmd.merge_add) begin
            acc_reg <= acc_reg + hdr_sz;
            n_reg   <= next_of(n_reg, hdr_sz, top_reg);
        end
        priority if (cmd.hit_wr) begin
            res_addr_reg   <= {g_plus_h[PG_W-1:0], 4'd0};
            res_status_reg <= ST_DONE;
        end else if (cmd.top_wr) begin
            res_addr_reg   <= {top_plus_h[PG_W-1:0], 4'd0};
            res_status_reg <= ST_DONE;
        end else if (cmd.res_zero) begin
            res_addr_reg   <= '0;
            res_status_reg <= ST_ZERO;
        end else if (cmd.res_oom) begin
            res_addr_reg   <= '0;
            res_status_reg <= ST_OOM;
        end else if (cmd.res_none) begin
            res_addr_reg   <= '0;
            res_status_reg <= ST_DONE;
        end else begin
            res_addr_reg   <= res_addr_reg;
            res_status_reg <= res_status_reg;
        end
        if (cmd.emit) begin
            m_address_reg <= res_addr_reg;
            m_status_reg  <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.top_wr) begin
                top_reg <= SW'(CW'(top_reg) + need_cw);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_free   = (op_reg == OP_FREE);
    assign stat.zero_req  = zero_reg;
    assign stat.bad_addr  = bad_reg;
    assign stat.g_lt_top  = (g_reg < top_reg);
    assign stat.g_lt_h    = (CW'(g_reg) < CW'(h_reg));
    assign stat.hdr_fit   = !hdr_a && (CW'(hdr_sz) >= need_cw);
    assign stat.hdr_split = (need_cw < CW'(hdr_sz));
    assign stat.free_hit  = (CW'(g_reg) == CW'(h_reg)) && (g_reg < top_reg) && hdr_a;
    assign stat.oom       = (need_cw > (CW'(HEAP_GRANULES) - CW'(top_reg)));
    assign stat.n_lt_top  = (n_reg < top_reg);
    assign stat.n_alloc   = hdr_a;
    assign stat.out_busy  = m_valid_reg && !m_ready;

    assign m_valid   = m_valid_reg;
    assign m_address = m_address_reg;
    assign m_status  = m_status_reg;

    a_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(top_reg) <= CW'(HEAP_GRANULES))
        else $error("Heap top has passed the end of the heap.");

    a_top_only_on_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.top_wr |=> $stable(top_reg))
        else $error("Heap top changed without a heap growth.");

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(we && re))
        else $error("Header memory read and written in the same cycle.");

    a_fail_has_no_address: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_OOM || m_status_reg == ST_ZERO)
        |-> (m_address_reg == '0))
        else $error("A failed allocation carries a non-zero address.");

    a_emit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("An item was emitted but the output is not valid.");

endmodule
